[sv/met_pkg.sv]
// ============================================================================
// met_pkg
// Shared types and constants for the Mandelbrot escape-time core.
// ============================================================================
`default_nettype none

package met_pkg;

  // Default number format: Q4.60 in 64 bits
  localparam int FRAC_BITS_DEF   = 60;
  localparam int COORD_WIDTH_DEF = 64;

  // Datapath widths (coordinate fields are 64 bits on the bus)
  localparam int DATA_W  = 64;
  localparam int HALF_W  = DATA_W / 2;
  localparam int ACC_W   = 2 * DATA_W;
  localparam int CNT_W   = 8;

  // Stream widths
  localparam int IN_TDATA_W  = 2 * DATA_W;
  localparam int OUT_TDATA_W = 16;

  // Iteration limit after reset
  localparam logic [CNT_W-1:0] MAX_ITER_RESET = 8'd80;

  // Partial-product sequencing: three 64x64 products, four 32x32 pieces each
  localparam int MUL_STEPS = 12;
  localparam int STEP_W    = 4;

  // Product group codes (step[3:2])
  localparam logic [1:0] GRP_RR = 2'd0;
  localparam logic [1:0] GRP_II = 2'd1;
  localparam logic [1:0] GRP_RI = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TEST,
    ST_CALC,
    ST_SAT,
    ST_ABS,
    ST_MUL,
    ST_DRAIN,
    ST_MAG,
    ST_DONE
  } met_state_t;

  // Controller to datapath
  typedef struct packed {
    logic              start;
    logic              calc;
    logic              sat;
    logic              abs_en;
    logic              mul_issue;
    logic [STEP_W-1:0] mul_step;
    logic              mag;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic escaped;
  } dp_status_t;

endpackage

`default_nettype wire

[sv/met_datapath.sv]
// ============================================================================
// met_datapath
// Fixed-point z <- z^2 + c datapath with one shared 32x32 multiplier.
// ============================================================================
`default_nettype none

module met_datapath #(
  parameter int FRAC_BITS   = 60,
  parameter int COORD_WIDTH = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire met_pkg::dp_cmd_t              cmd,
  input  wire logic [met_pkg::IN_TDATA_W-1:0] in_data,
  output met_pkg::dp_status_t                status
);
  import met_pkg::*;

  localparam int EXT_SH  = DATA_W - COORD_WIDTH;
  localparam int ESC_POS = 2 * FRAC_BITS + 2;
  localparam logic [DATA_W-1:0] Z_MAX = (DATA_W'(1) << (COORD_WIDTH - 1)) - DATA_W'(1);

  logic signed [DATA_W-1:0] cr_r, ci_r;
  logic [DATA_W-1:0]        zr_r, zi_r;
  logic [DATA_W-1:0]        zr_abs_r, zi_abs_r;
  logic [ACC_W-1:0]         rr_r, ii_r, ri_r;
  logic signed [ACC_W-1:0]  nr_r, ni_r;
  logic [DATA_W-1:0]        prod_r;
  logic [STEP_W-1:0]        prod_step_r;
  logic                     prod_vld_r;
  logic                     esc_r;

  // Saturate a wide signed value to the coordinate range, sign-extended to 64
  function automatic logic [DATA_W-1:0] sat_coord(input logic signed [ACC_W-1:0] v);
    logic [ACC_W-COORD_WIDTH:0] upper;
    logic [DATA_W-1:0]          res;
    upper = v[ACC_W-1:COORD_WIDTH-1];
    if ((&upper) || !(|upper)) begin
      res = v[DATA_W-1:0];
    end else if (v[ACC_W-1]) begin
      res = ~Z_MAX;
    end else begin
      res = Z_MAX;
    end
    return res;
  endfunction

  // Input coordinates: low COORD_WIDTH bits, sign-extended
  logic [DATA_W-1:0]        cr_shl, ci_shl;
  logic signed [DATA_W-1:0] cr_ext, ci_ext;
  always_comb begin
    cr_shl = in_data[DATA_W-1:0] << EXT_SH;
    ci_shl = in_data[IN_TDATA_W-1:DATA_W] << EXT_SH;
    cr_ext = $signed(cr_shl) >>> EXT_SH;
    ci_ext = $signed(ci_shl) >>> EXT_SH;
  end

  // Next z before saturation, floor rounding via arithmetic shift
  logic signed [ACC_W-1:0] diff, ri_sh, nr_nxt, ni_nxt;
  always_comb begin
    diff   = $signed(rr_r - ii_r);
    ri_sh  = $signed(ri_r) >>> (FRAC_BITS - 1);
    nr_nxt = (diff >>> FRAC_BITS) + $signed({{DATA_W{cr_r[DATA_W-1]}}, cr_r});
    ni_nxt = ri_sh + $signed({{DATA_W{ci_r[DATA_W-1]}}, ci_r});
  end

  // Multiplier operand select: group picks the product, low bits the halves
  logic [DATA_W-1:0] op_x, op_y;
  logic [HALF_W-1:0] half_x, half_y;
  always_comb begin
    unique case (cmd.mul_step[3:2])
      GRP_RR:  begin op_x = zr_abs_r; op_y = zr_abs_r; end
      GRP_II:  begin op_x = zi_abs_r; op_y = zi_abs_r; end
      default: begin op_x = zr_abs_r; op_y = zi_abs_r; end
    endcase
    half_x = cmd.mul_step[1] ? op_x[DATA_W-1:HALF_W] : op_x[HALF_W-1:0];
    half_y = cmd.mul_step[0] ? op_y[DATA_W-1:HALF_W] : op_y[HALF_W-1:0];
  end

  // Registered partial product aligned for accumulation
  logic [ACC_W-1:0] prod_aligned;
  always_comb begin
    unique case (prod_step_r[1:0])
      2'b00:   prod_aligned = {{DATA_W{1'b0}}, prod_r};
      2'b11:   prod_aligned = {prod_r, {DATA_W{1'b0}}};
      default: prod_aligned = {{HALF_W{1'b0}}, prod_r, {HALF_W{1'b0}}};
    endcase
  end

  // Magnitude squared and signed cross product
  logic [ACC_W-1:0] mag_sum;
  logic             ri_neg;
  always_comb begin
    mag_sum = rr_r + ii_r;
    ri_neg  = zr_r[DATA_W-1] ^ zi_r[DATA_W-1];
  end

  // Multiplier stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r <= 1'b0;
    end else begin
      prod_vld_r <= cmd.mul_issue;
    end
  end

  // Multiplier payload
  always_ff @(posedge clk) begin
    prod_r      <= DATA_W'(half_x * half_y);
    prod_step_r <= cmd.mul_step;
  end

  // Point and z registers
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      cr_r <= cr_ext;
      ci_r <= ci_ext;
      zr_r <= '0;
      zi_r <= '0;
    end else if (cmd.sat) begin
      zr_r <= sat_coord(nr_r);
      zi_r <= sat_coord(ni_r);
    end
    if (cmd.calc) begin
      nr_r <= nr_nxt;
      ni_r <= ni_nxt;
    end
    if (cmd.abs_en) begin
      zr_abs_r <= zr_r[DATA_W-1] ? (~zr_r + DATA_W'(1)) : zr_r;
      zi_abs_r <= zi_r[DATA_W-1] ? (~zi_r + DATA_W'(1)) : zi_r;
    end
  end

  // Product accumulators
  always_ff @(posedge clk) begin
    if (cmd.start || cmd.abs_en) begin
      rr_r <= '0;
      ii_r <= '0;
      ri_r <= '0;
    end else if (prod_vld_r) begin
      unique case (prod_step_r[3:2])
        GRP_RR:  rr_r <= rr_r + prod_aligned;
        GRP_II:  ii_r <= ii_r + prod_aligned;
        GRP_RI:  ri_r <= ri_r + prod_aligned;
        default: ;
      endcase
    end else if (cmd.mag && ri_neg) begin
      ri_r <= ~ri_r + ACC_W'(1);
    end
  end

  // Escape flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esc_r <= 1'b0;
    end else if (cmd.start) begin
      esc_r <= 1'b0;
    end else if (cmd.mag) begin
      esc_r <= |mag_sum[ACC_W-1:ESC_POS];
    end
  end

  assign status.escaped = esc_r;

  // Real part of saturated z always lies in the coordinate range
  a_z_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    $past(cmd.sat) |->
      ((&zr_r[DATA_W-1:COORD_WIDTH-1]) || !(|zr_r[DATA_W-1:COORD_WIDTH-1])))
    else $error("real part of z out of range after saturation");

endmodule

`default_nettype wire

[sv/met_ctrl.sv]
// ============================================================================
// met_ctrl
// Sequencer for the escape-time loop, limit register and result register.
// ============================================================================
`default_nettype none

module met_ctrl (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [met_pkg::CNT_W-1:0]      cfg_data,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic [met_pkg::OUT_TDATA_W-1:0]     out_tdata,
  output met_pkg::dp_cmd_t                    cmd,
  input  wire met_pkg::dp_status_t            status
);
  import met_pkg::*;

  met_state_t        state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [CNT_W-1:0]  n_r, n_nxt;
  logic [CNT_W-1:0]  max_iter_r;
  logic              out_vld_r, out_vld_nxt;
  logic [CNT_W-1:0]  out_cnt_r;
  logic              out_esc_r;
  logic              loop_done;
  logic              out_load;
  logic              mul_last;

  assign loop_done = status.escaped || (n_r == max_iter_r);
  assign mul_last  = (step_r == STEP_W'(MUL_STEPS - 1));
  assign out_load  = (state_r == ST_DONE) && (!out_vld_r || out_tready);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_tvalid) state_nxt = ST_TEST;
      ST_TEST:  state_nxt = loop_done ? ST_DONE : ST_CALC;
      ST_CALC:  state_nxt = ST_SAT;
      ST_SAT:   state_nxt = ST_ABS;
      ST_ABS:   state_nxt = ST_MUL;
      ST_MUL:   if (mul_last) state_nxt = ST_DRAIN;
      ST_DRAIN: state_nxt = ST_MAG;
      ST_MAG:   state_nxt = ST_TEST;
      ST_DONE:  if (out_load) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Outputs and datapath commands
  always_comb begin
    in_tready     = (state_r == ST_IDLE);
    cmd.start     = (state_r == ST_IDLE) && in_tvalid;
    cmd.calc      = (state_r == ST_CALC);
    cmd.sat       = (state_r == ST_SAT);
    cmd.abs_en    = (state_r == ST_ABS);
    cmd.mul_issue = (state_r == ST_MUL);
    cmd.mul_step  = step_r;
    cmd.mag       = (state_r == ST_MAG);
  end

  // Counters and result valid
  always_comb begin
    step_nxt = (state_r == ST_MUL) ? step_r + STEP_W'(1) : '0;
    n_nxt    = n_r;
    if (cmd.start) begin
      n_nxt = '0;
    end else if (cmd.mag) begin
      n_nxt = n_r + CNT_W'(1);
    end
    out_vld_nxt = out_vld_r;
    if (out_load) begin
      out_vld_nxt = 1'b1;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      step_r     <= '0;
      n_r        <= '0;
      out_vld_r  <= 1'b0;
      max_iter_r <= MAX_ITER_RESET;
    end else begin
      state_r   <= state_nxt;
      step_r    <= step_nxt;
      n_r       <= n_nxt;
      out_vld_r <= out_vld_nxt;
      if (cfg_valid) begin
        max_iter_r <= cfg_data;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_cnt_r <= n_r;
      out_esc_r <= status.escaped;
    end
  end

  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = OUT_TDATA_W'({out_esc_r, out_cnt_r});

  // An accepted point always starts with the limit test
  a_accept_test: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == ST_TEST))
    else $error("accepted beat did not start the loop");

  // Last partial product issue hands over to the drain cycle
  a_mul_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MUL && mul_last) |=> (state_r == ST_DRAIN && !cmd.mul_issue))
    else $error("multiplier sequence overran");

  // A loaded result is presented on the next cycle with the loop count
  a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (out_tvalid && out_tdata[CNT_W-1:0] == $past(n_r)))
    else $error("result beat lost or wrong count");

endmodule

`default_nettype wire

[sv/mandelbrot_escape_time_core.sv]
// ============================================================================
// mandelbrot_escape_time_core
// Escape-time iteration for one complex point per input beat.
// ============================================================================
//
//  Channel  Direction  Payload (lowest bits first)
//  in_*     slave      tdata[127:0]: c_real[63:0], c_imag[127:64]
//  out_*    master     tdata[15:0]:  iteration_count[7:0], escaped[8], zero fill
//  cfg_*    slave      data[7:0]:    max_iterations (reset 80)
//
//  Each iteration feeds the single 32x32 multiplier with the partial products
//  of zr^2, zi^2 and zr*zi; the rest form, saturate and test the new z.
//  One point is in work at a time; the next beat is taken once the result
//  sits in the output register, which holds it while out_tready is low.
//  Reset is synchronous, active low, and restores the limit to 80.
//
`default_nettype none

module mandelbrot_escape_time_core #(
  parameter int FRAC_BITS   = met_pkg::FRAC_BITS_DEF,
  parameter int COORD_WIDTH = met_pkg::COORD_WIDTH_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // c_real[63:0], c_imag[127:64]
  input  wire logic [met_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // iteration_count[7:0], escaped[8]
  output logic [met_pkg::OUT_TDATA_W-1:0]       out_tdata,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // max_iterations[7:0]
  input  wire logic [met_pkg::CNT_W-1:0]        cfg_data,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready
);
  import met_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // Sequencer
  met_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cmd        (cmd),
    .status     (status)
  );

  // Arithmetic
  met_datapath #(
    .FRAC_BITS   (FRAC_BITS),
    .COORD_WIDTH (COORD_WIDTH)
  ) u_datapath (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .in_data (in_tdata),
    .status  (status)
  );

endmodule

`default_nettype wire

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb - testbench for mandelbrot_escape_time_core
// Streams complex points through the core and checks every result against an
// in-bench predictor of the escape-time iteration. The run covers the number
// format's extremes, the escape boundary and limits from 0 to 255, and uses
// bursty input and a stalling output side.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = met_pkg::FRAC_BITS_DEF;

  // Q4.60 constants
  localparam logic [63:0] FX_ONE = 64'h1000_0000_0000_0000;
  localparam logic [63:0] C_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] C_MIN  = 64'h8000_0000_0000_0000;

  // Saturation bounds and the escape threshold, 4.0 at 120 fraction bits
  localparam logic signed [127:0] Z_HI = {65'd0, {63{1'b1}}};
  localparam logic signed [127:0] Z_LO = ~Z_HI;
  localparam logic [127:0] MAG_FOUR = 128'd1 << (2 * FRAC + 2);

  typedef struct packed {
    logic [7:0] count;
    logic       escaped;
  } escape_result_t;

  typedef enum int {PT_RAW, PT_REGION, PT_CORE, PT_RIM} point_kind_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic [met_pkg::IN_TDATA_W-1:0]  in_tdata = '0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [met_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [met_pkg::CNT_W-1:0]       cfg_data = '0;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;

  mandelbrot_escape_time_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_data   (cfg_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready)
  );

  // Bench state
  logic [127:0]   pending_points[$];    // {c_imag, c_real} waiting to be sent
  escape_result_t escape_predictions[$];
  logic [7:0]     iter_limit = met_pkg::MAX_ITER_RESET;
  longint         cycle_budget = 0;
  longint         cycle_count = 0;
  int             mismatches = 0;
  int             points_queued = 0;
  int             points_sent = 0;
  int             results_seen = 0;
  int             escaped_seen = 0;
  int             limit_writes = 0;

  // Clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Escape-time iteration on exact 128-bit products
  function automatic escape_result_t predict_escape(input logic [63:0] c_re,
                                                    input logic [63:0] c_im,
                                                    input logic [7:0] limit);
    logic signed [127:0] zr, zi, cr_w, ci_w, nr, ni;
    logic [127:0] mag;
    escape_result_t res;
    zr = '0;
    zi = '0;
    cr_w = {{64{c_re[63]}}, c_re};
    ci_w = {{64{c_im[63]}}, c_im};
    res = '0;
    while (res.count < limit && !res.escaped) begin
      // floor division by arithmetic shift, 2*zr*zi via one shift less
      nr = ((zr * zr - zi * zi) >>> FRAC) + cr_w;
      ni = ((zr * zi) >>> (FRAC - 1)) + ci_w;
      if (nr > Z_HI) nr = Z_HI;
      else if (nr < Z_LO) nr = Z_LO;
      if (ni > Z_HI) ni = Z_HI;
      else if (ni < Z_LO) ni = Z_LO;
      zr = nr;
      zi = ni;
      mag = zr * zr + zi * zi;
      res.escaped = (mag >= MAG_FOUR);
      res.count++;
    end
    return res;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Input side: bursts of beats with random gaps in between
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin : drive_points
    logic free;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      free = !in_tvalid;
      if (in_tvalid && in_tready) begin
        escape_predictions.push_back(
          predict_escape(in_tdata[63:0], in_tdata[127:64], iter_limit));
        points_sent++;
        free = 1'b1;
      end
      if (free) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (pending_points.size() > 0) begin
          in_tdata  <= pending_points.pop_front();
          in_tvalid <= 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 8);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Output side: switches between always ready, coin-flip and long stalls
  int stall_mode = 0;
  int mode_left = 0;
  int stall_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        mode_left = $urandom_range(50, 400);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= 1'($urandom_range(0, 1));
        default: begin
          if (stall_left > 0) begin
            stall_left--;
            out_tready <= 1'b0;
          end else begin
            out_tready <= 1'b1;
            if ($urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 40);
          end
        end
      endcase
    end
  end

  // Result checker
  always @(posedge clk) begin : check_results
    escape_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (out_tdata[8]) escaped_seen++;
      if (escape_predictions.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected result beat: count=%0d escaped=%0b",
                   out_tdata[7:0], out_tdata[8]);
      end else begin
        want = escape_predictions.pop_front();
        if (out_tdata[7:0] !== want.count || out_tdata[8] !== want.escaped) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: result %0d: count exp %0d got %0d, escaped exp %0b got %0b",
                     results_seen, want.count, out_tdata[7:0], want.escaped,
                     out_tdata[8]);
        end
      end
    end
  end

  // Watchdog, limit grows with the work queued
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > 4 * cycle_budget + 20000) begin
      $display("ERROR: timeout after %0d cycles, %0d results outstanding",
               cycle_count, escape_predictions.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Budget per point: every iteration, worst gap and stall, some slack
  task automatic queue_point(input logic [63:0] c_re, input logic [63:0] c_im);
    pending_points.push_back({c_im, c_re});
    points_queued++;
    cycle_budget += 18 * (longint'(iter_limit) + 1) + 120;
  endtask

  task automatic queue_random(input int n);
    logic [63:0] re, im, tmp;
    point_kind_t kind;
    int pick;
    repeat (n) begin
      pick = $urandom_range(0, 99);
      kind = (pick < 20) ? PT_RAW : (pick < 80) ? PT_REGION :
             (pick < 85) ? PT_CORE : PT_RIM;
      case (kind)
        PT_RAW: begin
          re = rand64();
          im = rand64();
        end
        // box around the set: real -2.0..0.5, imag -1.25..1.25
        PT_REGION: begin
          re = (rand64() % (FX_ONE * 5 / 2)) - 2 * FX_ONE;
          im = (rand64() % (FX_ONE * 5 / 2)) - FX_ONE * 5 / 4;
        end
        // near the origin, mostly runs to the limit
        PT_CORE: begin
          re = (rand64() % (FX_ONE / 2)) - FX_ONE / 4;
          im = (rand64() % (FX_ONE / 2)) - FX_ONE / 4;
        end
        // around |c| = 2, escapes in the first few updates
        default: begin
          re = FX_ONE * 3 / 2 + (rand64() % FX_ONE);
          if ($urandom_range(0, 1)) re = -re;
          im = (rand64() % (FX_ONE / 4)) - FX_ONE / 8;
          if ($urandom_range(0, 1)) begin
            tmp = re;
            re = im;
            im = tmp;
          end
        end
      endcase
      queue_point(re, im);
    end
  endtask

  // Hold off until every queued point has been sent and answered
  task automatic wait_idle();
    do @(posedge clk);
    while (results_seen != points_queued);
  endtask

  task automatic write_limit(input logic [7:0] value);
    @(posedge clk);
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    iter_limit = value;
    limit_writes++;
    cycle_budget += 100;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed points at the reset limit of 80
    queue_point(64'd0, 64'd0);
    queue_point(C_MIN, C_MIN);
    queue_point(C_MAX, C_MAX);
    queue_point(C_MIN, C_MAX);
    queue_point(C_MAX, C_MIN);
    queue_point(2 * FX_ONE, 64'd0);              // exactly on |c| = 2
    queue_point(-(2 * FX_ONE), 64'd0);
    queue_point(64'd0, 2 * FX_ONE);
    queue_point(2 * FX_ONE - 1, 64'd0);          // one LSB inside
    queue_point(-(2 * FX_ONE) + 1, 64'd0);
    queue_point(-FX_ONE, 64'd0);                 // period-2 orbit
    queue_point(FX_ONE / 4, 64'd0);              // cusp, slow convergence
    queue_point(FX_ONE / 4 + FX_ONE / 100, 64'd0);
    queue_point(-(FX_ONE * 3 / 4), FX_ONE / 10);
    queue_point(64'd0, FX_ONE);
    queue_point(FX_ONE * 3 / 10, FX_ONE / 2);
    queue_point(-(FX_ONE * 7 / 4), 64'd0);
    queue_point(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
    queue_point(64'd1, -64'd1);
    queue_point(-64'd1, 64'd0);
    wait_idle();

    // Limit of zero: no update at all
    write_limit(8'd0);
    queue_point(64'd0, 64'd0);
    queue_point(C_MAX, C_MAX);
    queue_point(2 * FX_ONE, 64'd0);
    wait_idle();

    // Limit of one, including escape on the only allowed update
    write_limit(8'd1);
    queue_point(2 * FX_ONE, 64'd0);
    queue_point(64'd0, 64'd0);
    queue_point(C_MIN, C_MIN);
    queue_random(200);
    wait_idle();

    write_limit(8'd2);
    queue_random(150);
    wait_idle();

    write_limit(8'd8);
    queue_random(450);
    wait_idle();

    write_limit(8'd32);
    queue_random(450);
    wait_idle();

    repeat (4) begin
      write_limit(8'($urandom_range(3, 64)));
      queue_random(150);
      wait_idle();
    end

    // Largest limit, kept short
    write_limit(8'd255);
    queue_point(64'd0, 64'd0);
    queue_point(FX_ONE / 4 + FX_ONE / 1000, 64'd0);
    queue_random(40);
    wait_idle();

    write_limit(8'd80);
    queue_random(150);
    wait_idle();

    // Give a stray result time to show up
    repeat (18 * int'(iter_limit) + 50) @(posedge clk);

    $display("Run covered %0d points over %0d limit writes (0, 1, 255 and between),",
             points_sent, limit_writes);
    $display("  with bursty input and stalled output: %0d escaped, %0d hit the limit.",
             escaped_seen, results_seen - escaped_seen);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
